### hdl/lbpm_pkg.sv
// Shared types and constants of the LRU block pool manager.
// No dependencies; the interfaces, the top level and the checker import this package.
package lbpm_pkg;

   // Pool size used when the top level is not given another one.
   localparam int BLOCKS_DEFAULT = 1024;

   // Fixed field widths of the request and response channels.
   localparam int CMD_W    = 2;
   localparam int IDX_W    = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   typedef enum logic [CMD_W-1:0] {
      CMD_ACQUIRE       = 2'd0,
      CMD_RELEASE       = 2'd1,
      CMD_MARK_USED     = 2'd2,
      CMD_MARK_MODIFIED = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NO_FREE     = 2'd1,
      STATUS_NOT_IN_USE  = 2'd2
   } status_type;

endpackage

### hdl/lbpm_req_if.sv
// Request channel of the LRU block pool manager: valid/ready plus the command fields.
// Depends on lbpm_pkg.
interface lbpm_req_if;
   import lbpm_pkg::*;

   logic                  valid;
   logic                  ready;
   cmd_type               cmd;
   logic [IDX_W-1:0]      block_index;

   modport source (output valid, output cmd, output block_index, input ready);
   modport sink   (input valid, input cmd, input block_index, output ready);
endinterface

### hdl/lbpm_rsp_if.sv
// Response channel of the LRU block pool manager: valid/ready plus the result fields.
// Depends on lbpm_pkg.
interface lbpm_rsp_if;
   import lbpm_pkg::*;

   logic                  valid;
   logic                  ready;
   status_type            status;
   logic [IDX_W-1:0]      granted_index;
   logic                  dirty;
   logic [COUNT_W-1:0]    free_count;
   logic [COUNT_W-1:0]    used_count;
   logic [IDX_W-1:0]      newest_index;
   logic [IDX_W-1:0]      oldest_index;

   modport source (output valid, output status, output granted_index, output dirty,
                   output free_count, output used_count, output newest_index,
                   output oldest_index, input ready);
   modport sink   (input valid, input status, input granted_index, input dirty,
                   input free_count, input used_count, input newest_index,
                   input oldest_index, output ready);
endinterface

### hdl/lbpm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lbpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lru_block_pool_manager_top.sv
// Top level of the LRU block pool manager.
// Depends on lbpm_pkg, lbpm_req_if, lbpm_rsp_if and lbpm_ram.
//
// The block manages a pool of BLOCKS cache blocks. Each request on req_bus carries a
// command (acquire, release, mark used, mark modified) and a block index; each request
// produces exactly one response on rsp_bus with a status, the granted block, the dirty
// flag of the touched block, the free and used counts and the MRU and LRU ends.
// Requests are taken one at a time: req_bus.ready is high only while the sequencer is
// idle. A request is processed by reading and rewriting the linked entries it touches
// in a single node memory (one read and one write per cycle, registered read data),
// so the memory port sets the pace. A rejected request goes straight to the response;
// other requests fetch their target node first and then patch only the neighbors
// they touch. The sequencer returns to idle as the response is registered.
// The response sits in an output register; the block keeps accepting and working
// on the next request while it waits, and only holds its finished result when the
// receiver has not yet taken the previous one.
// Reset is synchronous: the node memory is not swept.
// A high-water mark tracks how far the initial free list has been handed out, and
// entries at or above it read as their reset contents.
module lru_block_pool_manager_top #(
   parameter int BLOCKS = lbpm_pkg::BLOCKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   lbpm_req_if.sink          req_bus,
   lbpm_rsp_if.source        rsp_bus
);
   import lbpm_pkg::*;

   // Link values count up to BLOCKS, which stands for "no block".
   localparam int LW = $clog2(BLOCKS + 1);
   localparam int AW = $clog2(BLOCKS);
   localparam logic [LW-1:0] NONE = LW'(BLOCKS);

   // One memory word per block: flags and both recency links.
   typedef struct packed {
      logic          dirty;
      logic          used;
      logic [LW-1:0] prev;
      logic [LW-1:0] next;
   } node_type;

   localparam int NODE_W = $bits(node_type);

   // Sequencer: fetch the target node, then patch the previous neighbor, the next
   // neighbor and the old MRU block as the command requires, then respond.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TARGET,
      ST_PREV,
      ST_NEXT,
      ST_MRU,
      ST_DONE
   } state_type;

   function automatic state_type next_patch(input logic np, input logic nn, input logic nm);
      state_type s;
      if (np) begin
         s = ST_PREV;
      end else if (nn) begin
         s = ST_NEXT;
      end else if (nm) begin
         s = ST_MRU;
      end else begin
         s = ST_DONE;
      end
      return s;
   endfunction

   state_type     state_ff, state_in;

   // Request being worked on.
   cmd_type       cmd_ff, cmd_in;
   logic [LW-1:0] tgt_ff, tgt_in;
   logic [LW-1:0] p_ff, p_in;
   logic [LW-1:0] n_ff, n_in;
   logic [LW-1:0] old_mru_ff, old_mru_in;
   logic          need_p_ff, need_p_in;
   logic          need_n_ff, need_n_in;
   logic          need_m_ff, need_m_in;
   status_type    status_ff, status_in;
   logic [LW-1:0] granted_ff, granted_in;
   logic          dirty_ff, dirty_in;

   // List heads and counts.
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] mru_ff, mru_in;
   logic [LW-1:0] lru_ff, lru_in;
   logic [LW-1:0] free_total_ff, free_total_in;
   logic [LW-1:0] used_total_ff, used_total_in;
   logic [LW-1:0] hwm_ff, hwm_in;

   // Address of the last read, to recognize entries above the high-water mark.
   logic [LW-1:0] rd_addr_ff, rd_addr_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]   rsp_granted_ff, rsp_granted_in;
   logic               rsp_dirty_ff, rsp_dirty_in;
   logic [COUNT_W-1:0] rsp_free_ff, rsp_free_in;
   logic [COUNT_W-1:0] rsp_used_ff, rsp_used_in;
   logic [IDX_W-1:0]   rsp_newest_ff, rsp_newest_in;
   logic [IDX_W-1:0]   rsp_oldest_ff, rsp_oldest_in;

   // Memory port.
   logic              mem_wr_en;
   logic [LW-1:0]     mem_wr_addr;
   node_type          mem_wr_node;
   logic              mem_rd_en;
   logic [NODE_W-1:0] mem_rd_data;
   node_type          node_rd;

   logic req_accept;
   logic idx_out_of_range;

   lbpm_ram #(
      .WIDTH (NODE_W),
      .DEPTH (BLOCKS)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (AW'(mem_wr_addr)),
      .wr_data (NODE_W'(mem_wr_node)),
      .rd_en   (mem_rd_en),
      .rd_addr (AW'(rd_addr_in)),
      .rd_data (mem_rd_data)
   );

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign req_accept       = req_bus.valid && req_bus.ready;
   assign idx_out_of_range = (32'(req_bus.block_index) >= 32'(BLOCKS));

   // Entries at or above the high-water mark were never written and hold their
   // reset contents: unused, clean, unlinked, next pointing at the following block.
   always_comb begin
      if (rd_addr_ff >= hwm_ff) begin
         node_rd.dirty = 1'b0;
         node_rd.used  = 1'b0;
         node_rd.prev  = NONE;
         node_rd.next  = rd_addr_ff + 1'b1;
      end else begin
         node_rd = node_type'(mem_rd_data);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      tgt_in        = tgt_ff;
      p_in          = p_ff;
      n_in          = n_ff;
      old_mru_in    = old_mru_ff;
      need_p_in     = need_p_ff;
      need_n_in     = need_n_ff;
      need_m_in     = need_m_ff;
      status_in     = status_ff;
      granted_in    = granted_ff;
      dirty_in      = dirty_ff;
      free_head_in  = free_head_ff;
      mru_in        = mru_ff;
      lru_in        = lru_ff;
      free_total_in = free_total_ff;
      used_total_in = used_total_ff;
      hwm_in        = hwm_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = tgt_ff;
      mem_wr_node   = node_rd;

      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_dirty_in   = rsp_dirty_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_used_in    = rsp_used_ff;
      rsp_newest_in  = rsp_newest_ff;
      rsp_oldest_in  = rsp_oldest_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in     = req_bus.cmd;
               granted_in = '0;
               dirty_in   = 1'b0;
               status_in  = STATUS_OK;
               if (req_bus.cmd == CMD_ACQUIRE) begin
                  tgt_in = free_head_ff;
               end else begin
                  tgt_in = LW'(req_bus.block_index);
               end
               if (req_bus.cmd == CMD_ACQUIRE && free_head_ff == NONE) begin
                  status_in = STATUS_NO_FREE;
                  state_in  = ST_DONE;
               end else if (req_bus.cmd != CMD_ACQUIRE && idx_out_of_range) begin
                  status_in = STATUS_NOT_IN_USE;
                  state_in  = ST_DONE;
               end else begin
                  state_in  = ST_TARGET;
               end
            end
         end

         ST_TARGET: begin
            p_in       = node_rd.prev;
            n_in       = node_rd.next;
            old_mru_in = mru_ff;
            need_p_in  = 1'b0;
            need_n_in  = 1'b0;
            need_m_in  = 1'b0;
            dirty_in   = node_rd.dirty;
            case (cmd_ff)
               CMD_ACQUIRE: begin
                  // Pop the free head and link it in front of the recency list.
                  free_head_in  = node_rd.next;
                  free_total_in = free_total_ff - 1'b1;
                  used_total_in = used_total_ff + 1'b1;
                  if (tgt_ff == hwm_ff) begin
                     hwm_in = hwm_ff + 1'b1;
                  end
                  mem_wr_en        = 1'b1;
                  mem_wr_node.used = 1'b1;
                  mem_wr_node.prev = NONE;
                  mem_wr_node.next = mru_ff;
                  mru_in = tgt_ff;
                  if (lru_ff == NONE) begin
                     lru_in = tgt_ff;
                  end
                  granted_in = tgt_ff;
                  need_m_in  = (mru_ff != NONE);
               end
               CMD_RELEASE: begin
                  if (node_rd.used) begin
                     // Unlink from the recency list and push onto the free list.
                     mem_wr_en        = 1'b1;
                     mem_wr_node.used = 1'b0;
                     mem_wr_node.prev = NONE;
                     mem_wr_node.next = free_head_ff;
                     free_head_in  = tgt_ff;
                     free_total_in = free_total_ff + 1'b1;
                     used_total_in = used_total_ff - 1'b1;
                     if (node_rd.prev == NONE) begin
                        mru_in = node_rd.next;
                     end
                     if (node_rd.next == NONE) begin
                        lru_in = node_rd.prev;
                     end
                     need_p_in = (node_rd.prev != NONE);
                     need_n_in = (node_rd.next != NONE);
                  end else begin
                     status_in = STATUS_NOT_IN_USE;
                  end
               end
               default: begin
                  if (node_rd.used) begin
                     // Move to the MRU end. A block already there keeps its links.
                     mem_wr_en         = 1'b1;
                     mem_wr_node.dirty = node_rd.dirty || (cmd_ff == CMD_MARK_MODIFIED);
                     mem_wr_node.prev  = NONE;
                     dirty_in          = node_rd.dirty || (cmd_ff == CMD_MARK_MODIFIED);
                     if (node_rd.prev != NONE) begin
                        mem_wr_node.next = mru_ff;
                        mru_in           = tgt_ff;
                        if (node_rd.next == NONE) begin
                           lru_in = node_rd.prev;
                        end
                        need_p_in = 1'b1;
                        need_n_in = (node_rd.next != NONE);
                        need_m_in = (mru_ff != node_rd.prev);
                     end
                  end else begin
                     status_in = STATUS_NOT_IN_USE;
                  end
               end
            endcase
            state_in = next_patch(need_p_in, need_n_in, need_m_in);
         end

         ST_PREV: begin
            // The previous neighbor skips over the target. When it is also the old
            // MRU block of a mark, its back link to the target is set in the same write.
            mem_wr_en        = 1'b1;
            mem_wr_addr      = p_ff;
            mem_wr_node.next = n_ff;
            if (cmd_ff != CMD_RELEASE && p_ff == old_mru_ff) begin
               mem_wr_node.prev = tgt_ff;
            end
            state_in = next_patch(1'b0, need_n_ff, need_m_ff);
         end

         ST_NEXT: begin
            mem_wr_en        = 1'b1;
            mem_wr_addr      = n_ff;
            mem_wr_node.prev = p_ff;
            state_in         = next_patch(1'b0, 1'b0, need_m_ff);
         end

         ST_MRU: begin
            mem_wr_en        = 1'b1;
            mem_wr_addr      = old_mru_ff;
            mem_wr_node.prev = tgt_ff;
            state_in         = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_granted_in = IDX_W'(granted_ff);
               rsp_dirty_in   = dirty_ff;
               rsp_free_in    = COUNT_W'(free_total_ff);
               rsp_used_in    = COUNT_W'(used_total_ff);
               if (used_total_ff != '0 && mru_ff != NONE) begin
                  rsp_newest_in = IDX_W'(mru_ff);
               end else begin
                  rsp_newest_in = '0;
               end
               if (used_total_ff != '0 && lru_ff != NONE) begin
                  rsp_oldest_in = IDX_W'(lru_ff);
               end else begin
                  rsp_oldest_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A read is issued on every entry into a state that consumes memory data.
   always_comb begin
      mem_rd_en  = (state_in != state_ff) &&
                   (state_in inside {ST_TARGET, ST_PREV, ST_NEXT, ST_MRU});
      case (state_in)
         ST_TARGET: rd_addr_in = tgt_in;
         ST_PREV:   rd_addr_in = p_in;
         ST_NEXT:   rd_addr_in = n_in;
         ST_MRU:    rd_addr_in = old_mru_in;
         default:   rd_addr_in = rd_addr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= '0;
         mru_ff        <= NONE;
         lru_ff        <= NONE;
         free_total_ff <= NONE;
         used_total_ff <= '0;
         hwm_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         mru_ff        <= mru_in;
         lru_ff        <= lru_in;
         free_total_ff <= free_total_in;
         used_total_ff <= used_total_in;
         hwm_ff        <= hwm_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      tgt_ff         <= tgt_in;
      p_ff           <= p_in;
      n_ff           <= n_in;
      old_mru_ff     <= old_mru_in;
      need_p_ff      <= need_p_in;
      need_n_ff      <= need_n_in;
      need_m_ff      <= need_m_in;
      status_ff      <= status_in;
      granted_ff     <= granted_in;
      dirty_ff       <= dirty_in;
      rd_addr_ff     <= rd_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_dirty_ff   <= rsp_dirty_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_newest_ff  <= rsp_newest_in;
      rsp_oldest_ff  <= rsp_oldest_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.granted_index = rsp_granted_ff;
   assign rsp_bus.dirty         = rsp_dirty_ff;
   assign rsp_bus.free_count    = rsp_free_ff;
   assign rsp_bus.used_count    = rsp_used_ff;
   assign rsp_bus.newest_index  = rsp_newest_ff;
   assign rsp_bus.oldest_index  = rsp_oldest_ff;

endmodule

### hdl/lbpm_checker.sv
// Port-level checks of the LRU block pool manager, bound to the top level.
// Depends on lbpm_pkg and lru_block_pool_manager_top.
module lbpm_checker #(
   parameter int BLOCKS = lbpm_pkg::BLOCKS_DEFAULT
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input lbpm_pkg::status_type        rsp_status,
   input logic [lbpm_pkg::IDX_W-1:0]   rsp_granted_index,
   input logic [lbpm_pkg::COUNT_W-1:0] rsp_free_count,
   input logic [lbpm_pkg::COUNT_W-1:0] rsp_used_count,
   input logic [lbpm_pkg::IDX_W-1:0]   rsp_newest_index,
   input logic [lbpm_pkg::IDX_W-1:0]   rsp_oldest_index
);
   import lbpm_pkg::*;

   // A response stays offered until the receiver takes it.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // Every block is either free or in use.
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> COUNT_W'(rsp_free_count + rsp_used_count) == COUNT_W'(BLOCKS))
      else $error("free and used counts do not cover the pool");

   // An empty recency list reports both ends as zero.
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_used_count == '0 |-> rsp_newest_index == '0 && rsp_oldest_index == '0)
      else $error("ends reported for an empty recency list");

   // Only a successful request can grant a block.
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_granted_index == '0)
      else $error("block granted by a failed request");

   // The block is busy in the cycle after it takes a request.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while the previous one is in progress");

endmodule

bind lru_block_pool_manager_top lbpm_checker #(
   .BLOCKS (BLOCKS)
) u_lbpm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_status        (rsp_bus.status),
   .rsp_granted_index (rsp_bus.granted_index),
   .rsp_free_count    (rsp_bus.free_count),
   .rsp_used_count    (rsp_bus.used_count),
   .rsp_newest_index  (rsp_bus.newest_index),
   .rsp_oldest_index  (rsp_bus.oldest_index)
);
